@@ rtl/fqa_pkg.sv @@
// Package for the Q24.8 fixed-point ALU: opcodes, widths and pipeline types.
// Used by every module of the ALU; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fqa_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int DATA_W         = 32;
  localparam int DIVIDEND_W     = DATA_W + FRAC_BITS;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = (DIVIDEND_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int QUOT_W         = DIV_STAGES * BITS_PER_STAGE;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_GT     = 4'd4,
    OP_LT     = 4'd5,
    OP_GE     = 4'd6,
    OP_LE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_INC    = 4'd10,
    OP_DEC    = 4'd11,
    OP_TO_INT = 4'd12
  } op_t;

  typedef struct packed {
    op_t               kind;
    logic [DATA_W-1:0] value;
    logic              cmp;
    logic              dz;
    logic              neg_q;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [QUOT_W-1:0] dq;
    logic [DATA_W-1:0] dvsr;
  } div_t;

  typedef struct packed {
    item_t item;
    div_t  div;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/fixed_point_q24_8_alu.sv @@
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fqa_pkg, fqa_front, fqa_div_stage and fqa_back.
//
// Usage: one operation enters on the in_ channel (opcode and two raw Q24.8
// operands) and exactly one result leaves on the out_ channel, in order.
// Each transfer completes when valid and ready are both high at a clock edge.
// Every operation passes through the same pipeline: two front-end stages
// (decode and the 32 by 32 signed multiply, then the product scaling), twenty
// divider stages that each resolve two quotient bits of the 40-bit scaled
// dividend, and the output register. One operation may be accepted in every
// cycle in which the pipeline is not frozen.
// The whole pipeline advances together; when the output holds a result that
// the receiver has not taken, every stage freezes and in_ready falls, so no
// operation is lost or repeated. Empty slots still travel down the pipeline.
// A synchronous reset clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_q24_8_alu (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [3:0]                          in_kind,
  input  wire logic signed [fqa_pkg::DATA_W-1:0]   in_operand_a,
  input  wire logic signed [fqa_pkg::DATA_W-1:0]   in_operand_b,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [fqa_pkg::DATA_W-1:0]        out_result_value,
  output logic                                     out_compare_true,
  output logic                                     out_divide_by_zero
);

  logic            en;
  logic            pipe_valid [fqa_pkg::DIV_STAGES+1];
  fqa_pkg::stage_t pipe_data  [fqa_pkg::DIV_STAGES+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  fqa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .s2_valid     (pipe_valid[0]),
    .s2_data      (pipe_data[0])
  );

  for (genvar g = 0; g < fqa_pkg::DIV_STAGES; g++) begin : g_div
    fqa_div_stage u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .prev_valid (pipe_valid[g]),
      .prev_data  (pipe_data[g]),
      .next_valid (pipe_valid[g+1]),
      .next_data  (pipe_data[g+1])
    );
  end

  fqa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .last_valid         (pipe_valid[fqa_pkg::DIV_STAGES]),
    .last_data          (pipe_data[fqa_pkg::DIV_STAGES]),
    .out_valid          (out_valid),
    .out_result_value   (out_result_value),
    .out_compare_true   (out_compare_true),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

`default_nettype wire

@@ rtl/fqa_front.sv @@
// Front end of the ALU: decode, simple results, signed product and divider set-up.
// Two register stages; depends on fqa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqa_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic [3:0]                          in_kind,
  input  wire logic signed [fqa_pkg::DATA_W-1:0]   in_operand_a,
  input  wire logic signed [fqa_pkg::DATA_W-1:0]   in_operand_b,
  output logic                                     s2_valid,
  output fqa_pkg::stage_t                          s2_data
);

  logic                                   s1_valid_r;
  fqa_pkg::stage_t                        s1_data_r;
  fqa_pkg::stage_t                        s1_data_nxt;
  logic signed [2*fqa_pkg::DATA_W-1:0]    prod_r;
  logic signed [2*fqa_pkg::DATA_W-1:0]    prod_nxt;
  logic                                   s2_valid_r;
  fqa_pkg::stage_t                        s2_data_r;
  fqa_pkg::stage_t                        s2_data_nxt;
  logic signed [fqa_pkg::DATA_W-1:0]      shifted_a;
  logic [fqa_pkg::DATA_W-1:0]             abs_a;
  logic [fqa_pkg::DATA_W-1:0]             abs_b;
  logic signed [2*fqa_pkg::DATA_W-1:0]    prod_sh;
  fqa_pkg::op_t                           kind;

  always_comb begin
    kind      = fqa_pkg::op_t'(in_kind);
    shifted_a = in_operand_a >>> fqa_pkg::FRAC_BITS;
    abs_a     = in_operand_a[fqa_pkg::DATA_W-1] ? -in_operand_a : in_operand_a;
    abs_b     = in_operand_b[fqa_pkg::DATA_W-1] ? -in_operand_b : in_operand_b;
    prod_nxt  = in_operand_a * in_operand_b;

    s1_data_nxt            = '0;
    s1_data_nxt.item.kind  = kind;
    s1_data_nxt.item.neg_q = in_operand_a[fqa_pkg::DATA_W-1] ^ in_operand_b[fqa_pkg::DATA_W-1];
    s1_data_nxt.div.dq     = fqa_pkg::QUOT_W'({abs_a, {fqa_pkg::FRAC_BITS{1'b0}}});
    s1_data_nxt.div.dvsr   = abs_b;
    case (kind)
      fqa_pkg::OP_ADD: begin
        s1_data_nxt.item.value = in_operand_a + in_operand_b;
      end
      fqa_pkg::OP_SUB: begin
        s1_data_nxt.item.value = in_operand_a - in_operand_b;
      end
      fqa_pkg::OP_DIV: begin
        s1_data_nxt.item.dz = (in_operand_b == '0);
      end
      fqa_pkg::OP_GT: s1_data_nxt.item.cmp = in_operand_a > in_operand_b;
      fqa_pkg::OP_LT: s1_data_nxt.item.cmp = in_operand_a < in_operand_b;
      fqa_pkg::OP_GE: s1_data_nxt.item.cmp = in_operand_a >= in_operand_b;
      fqa_pkg::OP_LE: s1_data_nxt.item.cmp = in_operand_a <= in_operand_b;
      fqa_pkg::OP_EQ: s1_data_nxt.item.cmp = in_operand_a == in_operand_b;
      fqa_pkg::OP_NE: s1_data_nxt.item.cmp = in_operand_a != in_operand_b;
      fqa_pkg::OP_INC: begin
        s1_data_nxt.item.value = in_operand_a + fqa_pkg::DATA_W'(1);
      end
      fqa_pkg::OP_DEC: begin
        s1_data_nxt.item.value = in_operand_a - fqa_pkg::DATA_W'(1);
      end
      fqa_pkg::OP_TO_INT: begin
        if (in_operand_a[fqa_pkg::DATA_W-1] &&
            (in_operand_a[fqa_pkg::FRAC_BITS-1:0] != '0)) begin
          s1_data_nxt.item.value = shifted_a + fqa_pkg::DATA_W'(1);
        end else begin
          s1_data_nxt.item.value = shifted_a;
        end
      end
      default: begin
        s1_data_nxt.item.value = '0;
      end
    endcase
  end

  always_comb begin
    prod_sh     = prod_r >>> fqa_pkg::FRAC_BITS;
    s2_data_nxt = s1_data_r;
    if (s1_data_r.item.kind == fqa_pkg::OP_MUL) begin
      if (prod_r[2*fqa_pkg::DATA_W-1] && (prod_r[fqa_pkg::FRAC_BITS-1:0] != '0)) begin
        s2_data_nxt.item.value = prod_sh[fqa_pkg::DATA_W-1:0] + fqa_pkg::DATA_W'(1);
      end else begin
        s2_data_nxt.item.value = prod_sh[fqa_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_data_r <= s1_data_nxt;
      prod_r    <= prod_nxt;
      s2_data_r <= s2_data_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;

endmodule

`default_nettype wire

@@ rtl/fqa_div_stage.sv @@
// One stage of the restoring divider: two quotient bits per stage, registered.
// Depends on fqa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqa_div_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            prev_valid,
  input  wire fqa_pkg::stage_t prev_data,
  output logic                 next_valid,
  output fqa_pkg::stage_t      next_data
);

  logic                        valid_r;
  fqa_pkg::stage_t             data_r;
  fqa_pkg::stage_t             data_nxt;
  logic [fqa_pkg::DATA_W:0]    rem_sh;

  always_comb begin
    data_nxt = prev_data;
    rem_sh   = '0;
    for (int i = 0; i < fqa_pkg::BITS_PER_STAGE; i++) begin
      rem_sh = {data_nxt.div.rem, data_nxt.div.dq[fqa_pkg::QUOT_W-1]};
      data_nxt.div.dq = {data_nxt.div.dq[fqa_pkg::QUOT_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, data_nxt.div.dvsr}) begin
        rem_sh             = rem_sh - {1'b0, data_nxt.div.dvsr};
        data_nxt.div.dq[0] = 1'b1;
      end
      data_nxt.div.rem = rem_sh[fqa_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign next_valid = valid_r;
  assign next_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/fqa_back.sv @@
// Back end of the ALU: signs the quotient, picks the result and holds the output register.
// Depends on fqa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqa_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       last_valid,
  input  wire fqa_pkg::stage_t            last_data,
  output logic                            out_valid,
  output logic signed [fqa_pkg::DATA_W-1:0] out_result_value,
  output logic                            out_compare_true,
  output logic                            out_divide_by_zero
);

  logic                        out_valid_r;
  logic [fqa_pkg::DATA_W-1:0]  value_r;
  logic [fqa_pkg::DATA_W-1:0]  value_nxt;
  logic                        cmp_r;
  logic                        dz_r;
  logic [fqa_pkg::DATA_W-1:0]  quot;

  always_comb begin
    quot = last_data.div.dq[fqa_pkg::DATA_W-1:0];
    if (last_data.item.kind != fqa_pkg::OP_DIV) begin
      value_nxt = last_data.item.value;
    end else if (last_data.item.dz) begin
      value_nxt = '0;
    end else if (last_data.item.neg_q) begin
      value_nxt = -quot;
    end else begin
      value_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      cmp_r   <= last_data.item.cmp;
      dz_r    <= last_data.item.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = value_r;
  assign out_compare_true   = cmp_r;
  assign out_divide_by_zero = dz_r;

endmodule

`default_nettype wire

@@ rtl/fqa_checker.sv @@
// Port-level checks for the Q24.8 ALU, bound to the top level.
// Depends on fqa_pkg and fixed_point_q24_8_alu.
`timescale 1ns / 1ps
`default_nettype none

module fqa_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [fqa_pkg::DATA_W-1:0]        out_result_value,
  input wire logic                              out_compare_true,
  input wire logic                              out_divide_by_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before its transfer.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled although the output is empty.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_compare_true && out_divide_by_zero))
    else $error("Comparison and division flags both set.");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == '0)
    else $error("Division by zero with a non-zero result.");

endmodule

bind fixed_point_q24_8_alu fqa_checker u_fqa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_value   (out_result_value),
  .out_compare_true   (out_compare_true),
  .out_divide_by_zero (out_divide_by_zero)
);

`default_nettype wire
